// ===== sv/adaptive_flow_tick_throttle_assert.svh =====
// Assertion macros for the flow throttle
`ifndef ADAPTIVE_FLOW_TICK_THROTTLE_ASSERT_SVH
`define ADAPTIVE_FLOW_TICK_THROTTLE_ASSERT_SVH
`ifndef SYNTHESIS
`define AFT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define AFT_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AFT_ASSERT_IMP(label, clk, rst_n, a, c)
`define AFT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/aftt_pkg.sv =====
// Shared types and constants for the flow throttle
`default_nettype none
package aftt_pkg;
  localparam int TableEntries = 512;
  localparam int BudgetFloor = 8;
  localparam int BudgetCeil = 200;
  localparam int CooldownCeil = 10;

  localparam logic [1:0] REQ_SERVICE = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [2:0] V_PASS = 3'd0;
  localparam logic [2:0] V_ADMIT = 3'd1;
  localparam logic [2:0] V_BUDGET = 3'd2;
  localparam logic [2:0] V_COOL = 3'd3;
  localparam logic [2:0] V_FRAME = 3'd4;
  localparam logic [2:0] V_REMOVE = 3'd5;

  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_SWEEP = 3'd1;
  localparam logic [2:0] CFG_AGE = 3'd2;
  localparam logic [2:0] CFG_BSTEP = 3'd3;
  localparam logic [2:0] CFG_CSTEP = 3'd4;
  localparam logic [2:0] CFG_TARGET = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_DECIDE, ST_SWEEP, ST_SWEEP_END, ST_SCAN, ST_SCAN_END,
    ST_FINISH, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_init;
    logic sweep_init;
    logic scan_init;
    logic step;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic need_scan;
    logic last_idx;
    logic clear_busy;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/adaptive_flow_tick_throttle.sv =====
// Top level of the adaptive flow tick throttle
// channel | ports                         | handshake
// input   | start, busy, in_*             | start & !busy
// result  | out_strobe, out_*             | one-cycle strobe
// config  | cfg_valid, cfg_ready, cfg_*   | valid & ready
// Items with no table access (frame end, budget refusals, pass) go from DECIDE
// straight to FINISH and DONE. Lookups walk the table one entry a cycle.
// A sweep adds another walk of the table before the lookup.
// After reset and after a disabling write a clearing pass over the table
// runs with busy high. The result side cannot stall.
`default_nettype none
`include "adaptive_flow_tick_throttle_assert.svh"
module adaptive_flow_tick_throttle #(
  parameter int TABLE_ENTRIES = aftt_pkg::TableEntries,
  parameter int BUDGET_FLOOR = aftt_pkg::BudgetFloor,
  parameter int BUDGET_CEIL = aftt_pkg::BudgetCeil,
  parameter int COOLDOWN_CEIL = aftt_pkg::CooldownCeil
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_flow_id,
  input  wire logic        in_is_tracked_kind,
  input  wire logic [31:0] in_tick_number,
  input  wire logic [15:0] in_elapsed_ms,
  output logic             out_strobe,
  output logic [2:0]       out_verdict,
  output logic             out_untracked_full,
  output logic [9:0]       out_expired_dropped,
  output logic             out_flow_removed,
  output logic [7:0]       out_budget_now,
  output logic [3:0]       out_cooldown_now,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import aftt_pkg::*;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  aftt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  aftt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .BUDGET_FLOOR(BUDGET_FLOOR),
    .BUDGET_CEIL(BUDGET_CEIL), .COOLDOWN_CEIL(COOLDOWN_CEIL)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid & cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_req_type(in_req_type), .in_flow_id(in_flow_id),
    .in_is_tracked_kind(in_is_tracked_kind), .in_tick_number(in_tick_number),
    .in_elapsed_ms(in_elapsed_ms), .out_strobe(out_strobe),
    .out_verdict(out_verdict), .out_untracked_full(out_untracked_full),
    .out_expired_dropped(out_expired_dropped), .out_flow_removed(out_flow_removed),
    .out_budget_now(out_budget_now), .out_cooldown_now(out_cooldown_now)
  );

  `AFT_ASSERT_NEXT(a_load_busy, clk, rst_n, start && !busy, busy)
  `AFT_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, !busy || sts.clear_busy)
  `AFT_ASSERT_IMP(a_cool_range, clk, rst_n, out_strobe,
    out_cooldown_now != 4'd0 && out_budget_now != 8'd0)
endmodule
`default_nettype wire

// ===== sv/aftt_ctrl.sv =====
// Sequencing state machine for the flow throttle
`default_nettype none
module aftt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire aftt_pkg::sts_t sts,
  output aftt_pkg::cmd_t     cmd,
  output logic               busy
);
  import aftt_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.clear_busy) state_nxt = ST_CLEAR;
        else if (start) state_nxt = ST_DECIDE;
      end
      ST_CLEAR: if (sts.last_idx) state_nxt = ST_IDLE;
      ST_DECIDE: begin
        if (sts.need_sweep) state_nxt = ST_SWEEP;
        else if (sts.need_scan) state_nxt = ST_SCAN;
        else state_nxt = ST_FINISH;
      end
      ST_SWEEP: if (sts.last_idx) state_nxt = ST_SWEEP_END;
      ST_SWEEP_END: state_nxt = sts.need_scan ? ST_SCAN : ST_FINISH;
      ST_SCAN: if (sts.last_idx) state_nxt = ST_SCAN_END;
      ST_SCAN_END: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = sts.clear_busy;
        cmd.load = start & ~sts.clear_busy;
        cmd.clear_init = sts.clear_busy;
      end
      ST_CLEAR: cmd.step = 1'b1;
      ST_DECIDE: begin
        cmd.sweep_init = sts.need_sweep;
        cmd.scan_init = ~sts.need_sweep & sts.need_scan;
      end
      ST_SWEEP, ST_SCAN: cmd.step = 1'b1;
      ST_SWEEP_END: cmd.scan_init = sts.need_scan;
      ST_SCAN_END: ;
      ST_FINISH: cmd.finish = 1'b1;
      ST_DONE: cmd.emit = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/aftt_dp.sv =====
// Flow table, registers and decision datapath for the flow throttle
`default_nettype none
module aftt_dp #(
  parameter int TABLE_ENTRIES = aftt_pkg::TableEntries,
  parameter int BUDGET_FLOOR = aftt_pkg::BudgetFloor,
  parameter int BUDGET_CEIL = aftt_pkg::BudgetCeil,
  parameter int COOLDOWN_CEIL = aftt_pkg::CooldownCeil
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire aftt_pkg::cmd_t cmd,
  output aftt_pkg::sts_t      sts,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_idx,
  input  wire logic [15:0]    cfg_data,
  input  wire logic [1:0]     in_req_type,
  input  wire logic [63:0]    in_flow_id,
  input  wire logic           in_is_tracked_kind,
  input  wire logic [31:0]    in_tick_number,
  input  wire logic [15:0]    in_elapsed_ms,
  output logic                out_strobe,
  output logic [2:0]          out_verdict,
  output logic                out_untracked_full,
  output logic [9:0]          out_expired_dropped,
  output logic                out_flow_removed,
  output logic [7:0]          out_budget_now,
  output logic [3:0]          out_cooldown_now
);
  import aftt_pkg::*;
  localparam int AW = $clog2(TABLE_ENTRIES);

  // table memories
  logic [63:0] key_mem [TABLE_ENTRIES];
  logic [31:0] last_mem [TABLE_ENTRIES];
  logic        vld_mem [TABLE_ENTRIES];

  logic enabled_r;
  logic [15:0] sweep_int_r, age_r;
  logic [4:0] bstep_r;
  logic [2:0] cstep_r;
  logic [9:0] target_r;
  logic [7:0] admitted_r, budget_r;
  logic [31:0] prev_tick_r;
  logic [15:0] sweep_cnt_r;
  logic [3:0] cool_r;
  logic clear_pend_r;

  logic [1:0] req_r;
  logic [63:0] id_r;
  logic trk_r;
  logic [31:0] tick_r;
  logic [15:0] el_r;

  logic [AW-1:0] idx_r;
  logic [63:0] rd_key_r;
  logic [31:0] rd_last_r;
  logic rd_vld_r, rd_ok_r;
  logic [AW-1:0] rd_idx_r;
  logic scanning_r, sweeping_r, clearing_r;

  logic hit_r, free_found_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;
  logic [31:0] hit_last_r;
  logic [9:0] dropped_r;

  logic [2:0] verdict_r;
  logic full_r, removed_r;
  logic strobe_r;

  logic svc, tick_chg, bud_ok;
  logic [15:0] sweep_inc, sweep_lim, age_eff;
  logic [4:0] bs;
  logic [2:0] cs;
  logic [9:0] tgt;

  assign bs = (bstep_r == '0) ? 5'd1 : bstep_r;
  assign cs = (cstep_r == '0) ? 3'd1 : cstep_r;
  assign tgt = (target_r == '0) ? 10'd50 : target_r;
  assign sweep_lim = (sweep_int_r == '0) ? 16'd100 : sweep_int_r;
  assign age_eff = (age_r == '0) ? 16'd600 : age_r;
  assign svc = (req_r == REQ_SERVICE) & enabled_r & trk_r;
  assign tick_chg = tick_r != prev_tick_r;
  assign sweep_inc = sweep_cnt_r + 16'd1;
  assign bud_ok = (tick_chg ? 8'd0 : admitted_r) < budget_r;

  always_comb begin
    sts.need_sweep = svc & tick_chg & (sweep_inc >= sweep_lim);
    sts.need_scan = (svc & bud_ok) | ((req_r == REQ_REMOVE) & enabled_r);
    sts.last_idx = idx_r == AW'(TABLE_ENTRIES - 1);
    sts.clear_busy = clear_pend_r;
  end

  // config writes and budget registers
  logic [8:0] b10;
  logic [4:0] c2;
  assign b10 = 9'(bs) * 9'd10;
  assign c2 = 5'(cs) * 5'd2;
  logic [8:0] bsum;
  logic [8:0] bdif;
  logic [4:0] csum;
  logic [4:0] cdif;
  assign bsum = 9'(budget_r) + 9'(bs);
  assign bdif = 9'(budget_r) - 9'(bs);
  assign csum = 5'(cool_r) + 5'(cs);
  assign cdif = 5'(cool_r) - 5'(cs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0; sweep_int_r <= 16'd100; age_r <= 16'd600;
      bstep_r <= 5'd1; cstep_r <= 3'd1; target_r <= 10'd50;
      budget_r <= 8'd20; cool_r <= 4'd2; clear_pend_r <= 1'b1;
      admitted_r <= '0; prev_tick_r <= '0; sweep_cnt_r <= '0;
    end else begin
      if (cmd.clear_init) clear_pend_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ENABLE: begin
            if (cfg_data[0] & ~enabled_r) begin
              budget_r <= (b10 > 9'(BUDGET_CEIL)) ? 8'(BUDGET_CEIL) : b10[7:0];
              cool_r <= (c2 > 5'(COOLDOWN_CEIL)) ? 4'(COOLDOWN_CEIL) : c2[3:0];
            end else if (~cfg_data[0] & enabled_r) begin
              clear_pend_r <= 1'b1;
              admitted_r <= '0; prev_tick_r <= '0; sweep_cnt_r <= '0;
            end
            enabled_r <= cfg_data[0];
          end
          CFG_SWEEP: sweep_int_r <= cfg_data;
          CFG_AGE: age_r <= cfg_data;
          CFG_BSTEP: bstep_r <= cfg_data[4:0];
          CFG_CSTEP: cstep_r <= cfg_data[2:0];
          CFG_TARGET: target_r <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (svc) begin
          if (tick_chg) begin
            prev_tick_r <= tick_r;
            sweep_cnt_r <= sts.need_sweep ? 16'd0 : sweep_inc;
          end
          if (bud_ok && !(hit_r && (tick_r - hit_last_r) < 32'(cool_r)))
            admitted_r <= (tick_chg ? 8'd0 : admitted_r) + 8'd1;
          else if (tick_chg)
            admitted_r <= '0;
        end
        if (req_r == REQ_FRAME && enabled_r) begin
          if (el_r > 16'(tgt)) begin
            budget_r <= (bdif < 9'(BUDGET_FLOOR) || bdif[8]) ? 8'(BUDGET_FLOOR)
                                                             : bdif[7:0];
            cool_r <= (csum > 5'(COOLDOWN_CEIL)) ? 4'(COOLDOWN_CEIL) : csum[3:0];
          end else begin
            budget_r <= (bsum > 9'(BUDGET_CEIL)) ? 8'(BUDGET_CEIL) : bsum[7:0];
            cool_r <= (cdif[4] || cdif == 5'd0) ? 4'd1 : cdif[3:0];
          end
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type; id_r <= in_flow_id; trk_r <= in_is_tracked_kind;
      tick_r <= in_tick_number; el_r <= in_elapsed_ms;
    end
  end

  // table walk: index issue, registered read, evaluation in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0; sweeping_r <= 1'b0; clearing_r <= 1'b0;
      rd_ok_r <= 1'b0; idx_r <= '0;
    end else begin
      rd_ok_r <= cmd.step & (scanning_r | sweeping_r);
      if (cmd.clear_init | cmd.sweep_init | cmd.scan_init) idx_r <= '0;
      else if (cmd.step) idx_r <= idx_r + AW'(1);
      if (cmd.clear_init) clearing_r <= 1'b1;
      if (cmd.sweep_init) sweeping_r <= 1'b1;
      if (cmd.scan_init) scanning_r <= 1'b1;
      if (cmd.step && sts.last_idx) begin
        clearing_r <= 1'b0; sweeping_r <= 1'b0; scanning_r <= 1'b0;
      end
    end
  end

  logic expired;
  assign expired = rd_vld_r & ((tick_r - rd_last_r) > 32'(age_eff));
  logic rd_sweep_r;

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[idx_r];
    rd_last_r <= last_mem[idx_r];
    rd_vld_r <= vld_mem[idx_r];
    rd_idx_r <= idx_r;
    rd_sweep_r <= sweeping_r;
    if (cmd.step && clearing_r) vld_mem[idx_r] <= 1'b0;
    if (rd_ok_r && rd_sweep_r && expired) vld_mem[rd_idx_r] <= 1'b0;
    if (cmd.finish) begin
      if (svc && bud_ok && !(hit_r && (tick_r - hit_last_r) < 32'(cool_r))) begin
        if (hit_r) last_mem[hit_idx_r] <= tick_r;
        else if (free_found_r) begin
          vld_mem[free_idx_r] <= 1'b1;
          key_mem[free_idx_r] <= id_r;
          last_mem[free_idx_r] <= tick_r;
        end
      end
      if (req_r == REQ_REMOVE && enabled_r && hit_r) vld_mem[hit_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r <= 1'b0; free_found_r <= 1'b0; dropped_r <= '0;
    end else if (rd_ok_r) begin
      if (rd_sweep_r) begin
        if (expired && dropped_r != 10'd1023) dropped_r <= dropped_r + 10'd1;
      end else begin
        if (rd_vld_r && rd_key_r == id_r && !hit_r) begin
          hit_r <= 1'b1; hit_idx_r <= rd_idx_r; hit_last_r <= rd_last_r;
        end
        if (!rd_vld_r && !free_found_r) begin
          free_found_r <= 1'b1; free_idx_r <= rd_idx_r;
        end
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else strobe_r <= cmd.emit;
    if (cmd.finish) begin
      full_r <= 1'b0; removed_r <= 1'b0; verdict_r <= V_PASS;
      unique case (req_r)
        REQ_SERVICE: if (svc) begin
          if (!bud_ok) verdict_r <= V_BUDGET;
          else if (hit_r && (tick_r - hit_last_r) < 32'(cool_r)) verdict_r <= V_COOL;
          else begin
            verdict_r <= V_ADMIT;
            full_r <= ~hit_r & ~free_found_r;
          end
        end
        REQ_FRAME: verdict_r <= V_FRAME;
        REQ_REMOVE: begin
          verdict_r <= V_REMOVE;
          removed_r <= enabled_r & hit_r;
        end
        default: ;
      endcase
    end
  end

  assign out_strobe = strobe_r;
  assign out_verdict = verdict_r;
  assign out_untracked_full = full_r;
  assign out_expired_dropped = dropped_r;
  assign out_flow_removed = removed_r;
  assign out_budget_now = budget_r;
  assign out_cooldown_now = cool_r;
endmodule
`default_nettype wire

// ===== tb/tb_adaptive_flow_tick_throttle.sv =====
// Self-checking testbench for the adaptive flow tick throttle
`default_nettype none
module tb_adaptive_flow_tick_throttle;
  import aftt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam int NumSlots = 512;
  localparam longint CycleLimit = 6000000;

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] id;
    logic        tracked;
    logic [31:0] tick;
    logic [15:0] elapsed;
  } request_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       full;
    logic [9:0] dropped;
    logic       removed;
    logic [7:0] budget;
    logic [3:0] cooldown;
  } outcome_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_req_type;
  logic [63:0] in_flow_id;
  logic in_is_tracked_kind;
  logic [31:0] in_tick_number;
  logic [15:0] in_elapsed_ms;
  logic out_strobe, out_untracked_full, out_flow_removed;
  logic [2:0] out_verdict;
  logic [9:0] out_expired_dropped;
  logic [7:0] out_budget_now;
  logic [3:0] out_cooldown_now;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  adaptive_flow_tick_throttle i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_flow_id(in_flow_id),
    .in_is_tracked_kind(in_is_tracked_kind), .in_tick_number(in_tick_number),
    .in_elapsed_ms(in_elapsed_ms), .out_strobe(out_strobe),
    .out_verdict(out_verdict), .out_untracked_full(out_untracked_full),
    .out_expired_dropped(out_expired_dropped), .out_flow_removed(out_flow_removed),
    .out_budget_now(out_budget_now), .out_cooldown_now(out_cooldown_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the throttle state
  logic [63:0] slot_key [NumSlots];
  logic [31:0] slot_tick [NumSlots];
  logic        slot_used [NumSlots];
  int unsigned admitted, prev_tick, sweep_cnt;
  int budget, cooldown;
  int unsigned enabled, sweep_iv, age_lim, bstep, cstep, target_ms;

  outcome_t verdict_q[$];
  int errors, words_sent, words_checked, full_seen, drops_seen;
  longint cycles;
  bit no_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned or_dflt(int unsigned v, int unsigned d);
    return v == 0 ? d : v;
  endfunction

  function automatic void clear_shadow();
    foreach (slot_used[i]) slot_used[i] = 0;
  endfunction

  function automatic void shadow_cfg(logic [2:0] idx, logic [15:0] val);
    int b, c;
    case (idx)
      CFG_ENABLE: begin
        if (val[0] && enabled == 0) begin
          b = or_dflt(bstep, 1) * 10;
          c = or_dflt(cstep, 1) * 2;
          budget = b > BudgetCeil ? BudgetCeil : b;
          cooldown = c > CooldownCeil ? CooldownCeil : c;
        end else if (!val[0] && enabled == 1) begin
          clear_shadow();
          admitted = 0;
          prev_tick = 0;
          sweep_cnt = 0;
        end
        enabled = val[0];
      end
      CFG_SWEEP: sweep_iv = val;
      CFG_AGE: age_lim = val;
      CFG_BSTEP: bstep = val[4:0];
      CFG_CSTEP: cstep = val[2:0];
      CFG_TARGET: target_ms = val[9:0];
      default: ;
    endcase
  endfunction

  function automatic int find_slot(logic [63:0] id);
    for (int i = 0; i < NumSlots; i++)
      if (slot_used[i] && slot_key[i] == id) return i;
    return -1;
  endfunction

  function automatic outcome_t throttle_decide(request_t r);
    outcome_t o;
    int slot, bs, cs;
    logic [31:0] d;
    o = '0;
    if (r.req == REQ_SERVICE) begin
      if (enabled == 1 && r.tracked) begin
        if (r.tick != prev_tick) begin
          prev_tick = r.tick;
          admitted = 0;
          sweep_cnt = (sweep_cnt + 1) & 16'hFFFF;
          if (sweep_cnt >= or_dflt(sweep_iv, 100)) begin
            sweep_cnt = 0;
            for (int i = 0; i < NumSlots; i++) begin
              d = r.tick - slot_tick[i];
              if (slot_used[i] && d > or_dflt(age_lim, 600)) begin
                slot_used[i] = 0;
                if (o.dropped < 1023) o.dropped++;
              end
            end
          end
        end
        if (int'(admitted) >= budget) begin
          o.verdict = V_BUDGET;
        end else begin
          slot = find_slot(r.id);
          d = (slot >= 0) ? r.tick - slot_tick[slot] : '0;
          if (slot >= 0 && d < 32'(cooldown)) begin
            o.verdict = V_COOL;
          end else begin
            if (slot < 0) begin
              for (int i = 0; i < NumSlots; i++)
                if (!slot_used[i]) begin
                  slot = i;
                  break;
                end
              if (slot >= 0) begin
                slot_used[slot] = 1;
                slot_key[slot] = r.id;
              end else begin
                o.full = 1;
              end
            end
            if (slot >= 0) slot_tick[slot] = r.tick;
            admitted = (admitted + 1) & 8'hFF;
            o.verdict = V_ADMIT;
          end
        end
      end
    end else if (r.req == REQ_FRAME) begin
      o.verdict = V_FRAME;
      if (enabled == 1) begin
        bs = or_dflt(bstep, 1);
        cs = or_dflt(cstep, 1);
        if (r.elapsed > or_dflt(target_ms, 50)) begin
          budget = budget - bs < BudgetFloor ? BudgetFloor : budget - bs;
          cooldown = cooldown + cs > CooldownCeil ? CooldownCeil : cooldown + cs;
        end else begin
          budget = budget + bs > BudgetCeil ? BudgetCeil : budget + bs;
          cooldown = cooldown - cs < 1 ? 1 : cooldown - cs;
        end
      end
    end else if (r.req == REQ_REMOVE) begin
      o.verdict = V_REMOVE;
      if (enabled == 1) begin
        slot = find_slot(r.id);
        if (slot >= 0) begin
          slot_used[slot] = 0;
          o.removed = 1;
        end
      end
    end
    o.budget = budget[7:0];
    o.cooldown = cooldown[3:0];
    return o;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (verdict_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = verdict_q.pop_front();
        words_checked++;
        if (out_verdict !== e.verdict)
          report($sformatf("verdict %0d exp %0d", out_verdict, e.verdict));
        if (out_untracked_full !== e.full)
          report($sformatf("untracked_full %0b exp %0b", out_untracked_full, e.full));
        if (out_expired_dropped !== e.dropped)
          report($sformatf("expired_dropped %0d exp %0d", out_expired_dropped, e.dropped));
        if (out_flow_removed !== e.removed)
          report($sformatf("flow_removed %0b exp %0b", out_flow_removed, e.removed));
        if (out_budget_now !== e.budget)
          report($sformatf("budget_now %0d exp %0d", out_budget_now, e.budget));
        if (out_cooldown_now !== e.cooldown)
          report($sformatf("cooldown_now %0d exp %0d", out_cooldown_now, e.cooldown));
        if (e.full) full_seen++;
        drops_seen += e.dropped;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(request_t r);
    int gap;
    start <= 1;
    in_req_type <= r.req;
    in_flow_id <= r.id;
    in_is_tracked_kind <= r.tracked;
    in_tick_number <= r.tick;
    in_elapsed_ms <= r.elapsed;
    do @(posedge clk); while (busy);
    verdict_q.push_back(throttle_decide(r));
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(logic [1:0] req, logic [63:0] id, logic tracked,
                      logic [31:0] tick, logic [15:0] elapsed);
    request_t r;
    r = '{req, id, tracked, tick, elapsed};
    send_word(r);
  endtask

  task automatic drain();
    start <= 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_cfg(idx, val);
    cfg_valid <= 0;
  endtask

  task automatic test_disabled();
    send(REQ_SERVICE, '1, 1, '1, '1);
    send(REQ_FRAME, '0, 0, '0, '0);
    send(REQ_FRAME, '1, 1, 32'h1, '1);
    send(REQ_REMOVE, '1, 1, '0, '0);
    send(REQ_UNDEF, 64'h5555_AAAA_5555_AAAA, 1, 32'hAAAA_5555, 16'h5555);
  endtask

  task automatic test_zero_regs();
    write_reg(CFG_BSTEP, 16'd0);
    write_reg(CFG_CSTEP, 16'd0);
    write_reg(CFG_TARGET, 16'd0);
    write_reg(CFG_SWEEP, 16'd0);
    write_reg(CFG_AGE, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_ENABLE, 16'd1);
    send(REQ_SERVICE, 64'd0, 1, 32'd5, '0);
    send(REQ_SERVICE, 64'd0, 1, 32'd5, '0);
    send(REQ_SERVICE, 64'd0, 1, 32'd6, '0);
    send(REQ_SERVICE, 64'd0, 1, 32'd7, '0);
    for (int i = 1; i <= 10; i++) send(REQ_SERVICE, 64'(i), 1, 32'd7, '0);
    send(REQ_SERVICE, '1, 0, 32'd9, '0);
    send(REQ_UNDEF, '1, 1, 32'd9, '1);
    send(REQ_FRAME, '0, 0, '0, 16'd51);
    send(REQ_FRAME, '0, 0, '0, 16'd50);
    send(REQ_REMOVE, 64'd3, 0, '0, '0);
    send(REQ_REMOVE, 64'd3, 0, '0, '0);
    send(REQ_SERVICE, 64'd3, 1, '1, '0);
  endtask

  task automatic test_saturation();
    write_reg(CFG_ENABLE, 16'd0);
    write_reg(CFG_BSTEP, 16'd31);
    write_reg(CFG_CSTEP, 16'd7);
    write_reg(CFG_TARGET, 16'd1023);
    write_reg(CFG_ENABLE, 16'd1);
    send(REQ_FRAME, '0, 0, '0, 16'd0);
    for (int i = 0; i < 8; i++) send(REQ_FRAME, '0, 0, '0, 16'hFFFF);
    send(REQ_FRAME, '0, 0, '0, 16'd1023);
    send(REQ_FRAME, '0, 0, '0, 16'd1024);
  endtask

  task automatic test_table_full();
    logic [31:0] salt;
    salt = $urandom;
    write_reg(CFG_ENABLE, 16'd0);
    write_reg(CFG_BSTEP, 16'd20);
    write_reg(CFG_CSTEP, 16'd1);
    write_reg(CFG_SWEEP, 16'hFFFF);
    write_reg(CFG_AGE, 16'hFFFF);
    write_reg(CFG_TARGET, 16'd1000);
    write_reg(CFG_ENABLE, 16'd1);
    no_idle = 1;
    for (int i = 0; i < NumSlots + 8; i++)
      send(REQ_SERVICE, {salt, 32'(i)}, 1, 32'(100 + i / 150), '0);
    no_idle = 0;
    send(REQ_REMOVE, {salt, 32'd77}, 1, '0, '0);
    send(REQ_SERVICE, {salt, 32'd9999}, 1, 32'd110, '0);
    send(REQ_SERVICE, {salt, 32'd9998}, 1, 32'd110, '0);
  endtask

  task automatic random_phase(int count, int mode);
    logic [63:0] pool [12];
    logic [31:0] tick;
    request_t r;
    int k;
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    write_reg(CFG_ENABLE, 16'd0);
    case (mode)
      0: begin
        write_reg(CFG_SWEEP, 16'($urandom_range(1, 3)));
        write_reg(CFG_AGE, 16'($urandom_range(1, 8)));
      end
      1: begin
        write_reg(CFG_SWEEP, 16'd1);
        write_reg(CFG_AGE, 16'hFFFF);
      end
      default: begin
        write_reg(CFG_SWEEP, 16'($urandom_range(1, 12)));
        write_reg(CFG_AGE, 16'($urandom_range(1, 30)));
      end
    endcase
    write_reg(CFG_BSTEP, 16'($urandom_range(0, 31)));
    write_reg(CFG_CSTEP, 16'($urandom_range(0, 7)));
    write_reg(CFG_TARGET, 16'($urandom_range(0, 1023)));
    write_reg(CFG_ENABLE, 16'd1);
    tick = (mode == 1) ? 32'hFFFF_FFF0 : $urandom;
    for (int n = 0; n < count; n++) begin
      no_idle = ((n / 10) % 3 == 2);
      if ($urandom_range(0, 3) == 0) tick += $urandom_range(1, 3);
      k = $urandom_range(0, 99);
      r.id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : pool[$urandom_range(0, 11)];
      r.tick = ($urandom_range(0, 49) == 0) ? $urandom : tick;
      r.tracked = 1;
      r.elapsed = $urandom_range(0, 1) ? 16'($urandom_range(0, 1100)) : 16'($urandom);
      if (k < 72) r.req = REQ_SERVICE;
      else if (k < 84) r.req = REQ_FRAME;
      else if (k < 93) r.req = REQ_REMOVE;
      else if (k < 97) begin
        r.req = REQ_SERVICE;
        r.tracked = 0;
      end else r.req = REQ_UNDEF;
      send_word(r);
    end
    no_idle = 0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 0;
    rst_n = 0;
    start = 0;
    in_req_type = '0;
    in_flow_id = '0;
    in_is_tracked_kind = 0;
    in_tick_number = '0;
    in_elapsed_ms = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    clear_shadow();
    foreach (slot_tick[i]) slot_tick[i] = '0;
    foreach (slot_key[i]) slot_key[i] = '0;
    admitted = 0;
    prev_tick = 0;
    sweep_cnt = 0;
    budget = 20;
    cooldown = 2;
    enabled = 0;
    sweep_iv = 100;
    age_lim = 600;
    bstep = 1;
    cstep = 1;
    target_ms = 50;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_disabled();
    test_zero_regs();
    test_saturation();
    test_table_full();
    random_phase(40, 0);
    random_phase(30, 1);
    random_phase(30, 2);

    drain();
    repeat (40) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d full-table admits, %0d swept",
             words_sent, words_checked, full_seen, drops_seen);
    $display("covered disabled, zero and saturating registers, table overflow, random phases");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
